// ===== rtl/grdk_pkg.sv =====
// grid diagonal-cut spanning forest: shared sizes, key layout and register codes
// no dependencies; used by grid_diagonal_cut_kruskal_mst_top
`default_nettype none

package grdk_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
	localparam int MAX_NODES = (MAX_ROWS + 1) * MAX_COLS + MAX_ROWS * (MAX_COLS + 1);

	localparam int CFG_W   = 7;
	localparam int COST_W  = 16;
	localparam int TOTAL_W = 32;

	localparam int CELL_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNT_W   = $clog2(MAX_CELLS + 1);
	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int NCNT_W  = $clog2(MAX_NODES + 1);
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RDIM_W  = $clog2(MAX_ROWS + 1);
	localparam int CDIM_W  = $clog2(MAX_COLS + 1);
	localparam int PROD_W  = RDIM_W + CDIM_W;
	localparam int CELL_DW = 1 + COST_W;

	// radix sort on the cost, four bits a pass
	localparam int DIGIT_W = 4;
	localparam int NBUCKET = 1 << DIGIT_W;
	localparam int NDIGIT  = COST_W / DIGIT_W;
	localparam int PASS_W  = (NDIGIT > 1) ? $clog2(NDIGIT) : 1;

	// register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic              slash;
		logic [COST_W-1:0] cost;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} key_t;

endpackage

`default_nettype wire

// ===== rtl/grid_diagonal_cut_kruskal_mst_top.sv =====
// grid diagonal-cut minimum spanning forest, top level
// uses grdk_pkg for sizes and key layout; holds cell, order and parent memories
//
// usage
//   cells enter on the in channel (is_slash, cell_cost, last_cell) in row-major
//   order, one transfer per cycle while the block is idle. rows and cols are set
//   over the cfg channel (index 0 rows, index 1 cols), cfg_ready is always high.
//   the transfer that carries last_cell starts the solve; in_stall stays high
//   until the result has been loaded into the output register.
//   solve phases: copy of the cells, parent init over (rows+1)*cols+rows*(cols+1)
//   nodes, four radix passes, then two passes over the sorted cells, each join
//   taking at least four union-find steps (find and compression walk for both
//   ends); the single read port of the parent memory sets the pace of the last
//   phase, which takes longer when the finds walk longer paths.
//   total_cost is held in an output register; while out_stall is high the
//   result stays put and a finished solve waits for the register to free up,
//   cells for the next grid are taken once the result is in the output register.
//   reset clears control state and sets rows and cols to 1; memories are not
//   cleared, the parent table is rebuilt in every solve, after the copy.
`default_nettype none

module grid_diagonal_cut_kruskal_mst_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire                           cfg_index,
	input  wire  [grdk_pkg::CFG_W-1:0]    cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire                           is_slash,
	input  wire  [grdk_pkg::COST_W-1:0]   cell_cost,
	input  wire                           last_cell,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [grdk_pkg::TOTAL_W-1:0]  total_cost
);

	localparam int CELL_W  = grdk_pkg::CELL_W;
	localparam int CNT_W   = grdk_pkg::CNT_W;
	localparam int NODE_W  = grdk_pkg::NODE_W;
	localparam int NCNT_W  = grdk_pkg::NCNT_W;
	localparam int ROW_W   = grdk_pkg::ROW_W;
	localparam int COL_W   = grdk_pkg::COL_W;
	localparam int RDIM_W  = grdk_pkg::RDIM_W;
	localparam int CDIM_W  = grdk_pkg::CDIM_W;
	localparam int PROD_W  = grdk_pkg::PROD_W;
	localparam int DIGIT_W = grdk_pkg::DIGIT_W;
	localparam int PASS_W  = grdk_pkg::PASS_W;
	localparam int TOTAL_W = grdk_pkg::TOTAL_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_COPY  = 4'd1;
	localparam logic [3:0] S_PINIT = 4'd2;
	localparam logic [3:0] S_CNT   = 4'd3;
	localparam logic [3:0] S_PFX   = 4'd4;
	localparam logic [3:0] S_SCT   = 4'd5;
	localparam logic [3:0] S_JRD   = 4'd6;
	localparam logic [3:0] S_JLAT  = 4'd7;
	localparam logic [3:0] S_JSIDE = 4'd8;
	localparam logic [3:0] S_FRD   = 4'd9;
	localparam logic [3:0] S_FCHK  = 4'd10;
	localparam logic [3:0] S_CRD   = 4'd11;
	localparam logic [3:0] S_CCHK  = 4'd12;
	localparam logic [3:0] S_UNI   = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	// memories
	logic [grdk_pkg::CELL_DW-1:0] cell_mem [grdk_pkg::MAX_CELLS];
	grdk_pkg::key_t               ord_a    [grdk_pkg::MAX_CELLS];
	grdk_pkg::key_t               ord_b    [grdk_pkg::MAX_CELLS];
	logic [NODE_W-1:0]            par_mem  [grdk_pkg::MAX_NODES];

	logic [grdk_pkg::CELL_DW-1:0] cm_rdata_q;
	grdk_pkg::key_t               orda_rdata_q, ordb_rdata_q;
	logic [NODE_W-1:0]            par_rdata_q;

	logic                         cm_we;
	logic [CELL_W-1:0]            cm_raddr;
	logic                         orda_we, ordb_we;
	logic [CELL_W-1:0]            ord_waddr, ord_raddr;
	grdk_pkg::key_t               ord_wdata;
	logic                         par_we;
	logic [NODE_W-1:0]            par_waddr, par_wdata, par_raddr;

	// control and datapath registers
	logic [3:0]                   state_q;
	logic [grdk_pkg::CFG_W-1:0]   rows_q, cols_q;
	logic [CNT_W-1:0]             loaded_q, n_q, nld_q, k_q;
	logic [RDIM_W-1:0]            er_q;
	logic [CDIM_W-1:0]            ec_q;
	logic [NODE_W-1:0]            pre_q;
	logic [NCNT_W-1:0]            nodes_q, nd_q;
	logic [ROW_W-1:0]             ci_q, ci_s1;
	logic [COL_W-1:0]             cj_q, cj_s1;
	logic [CNT_W-1:0]             k_s1;
	logic                         v_s1;
	logic [PASS_W-1:0]            pass_q;
	logic [CNT_W-1:0]             hist_q [grdk_pkg::NBUCKET];
	logic [DIGIT_W-1:0]           b_q;
	logic [CNT_W-1:0]             acc_q;
	logic                         zpass_q;
	grdk_pkg::key_t               jkey_q;
	logic [NODE_W-1:0]            ca_q, cb_q, e1a_q, e1b_q;
	logic                         e_q, side_q;
	logic [NODE_W-1:0]            cur_q, root_q, ra_q;
	logic [TOTAL_W-1:0]           total_q;
	logic                         out_valid_q;
	logic [TOTAL_W-1:0]           out_total_q;

	// effective dimensions from the registers
	logic [RDIM_W-1:0]            er;
	logic [CDIM_W-1:0]            ec;
	logic [PROD_W-1:0]            n_full;
	logic [CNT_W-1:0]             n_now;
	logic [CNT_W-1:0]             loaded_nx, nld_nx;
	logic                         in_acc, cell_wr, out_free, out_load;

	always_comb begin
		if (rows_q == '0)
			er = RDIM_W'(1);
		else if (rows_q > grdk_pkg::MAX_ROWS)
			er = RDIM_W'(grdk_pkg::MAX_ROWS);
		else
			er = RDIM_W'(rows_q);
		if (cols_q == '0)
			ec = CDIM_W'(1);
		else if (cols_q > grdk_pkg::MAX_COLS)
			ec = CDIM_W'(grdk_pkg::MAX_COLS);
		else
			ec = CDIM_W'(cols_q);
	end

	assign n_full    = PROD_W'(er) * PROD_W'(ec);
	assign n_now     = CNT_W'(n_full);
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cell_wr   = in_acc && (loaded_q < n_now);
	assign loaded_nx = cell_wr ? loaded_q + CNT_W'(1) : loaded_q;
	assign nld_nx    = (loaded_nx > n_now) ? n_now : loaded_nx;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == S_OUT) && out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign total_cost = out_total_q;

	// sort source and digit
	grdk_pkg::key_t     src_key;
	logic [DIGIT_W-1:0] digit;
	logic [DIGIT_W-1:0] hx;
	grdk_pkg::key_t     copy_key;
	grdk_pkg::key_t     sorted_key;

	assign src_key    = pass_q[0] ? ordb_rdata_q : orda_rdata_q;
	assign sorted_key = (grdk_pkg::NDIGIT % 2 == 1) ? ordb_rdata_q : orda_rdata_q;
	assign digit      = DIGIT_W'(src_key.cost >> (pass_q * DIGIT_W));
	assign hx         = (state_q == S_PFX) ? b_q : digit;

	always_comb begin
		copy_key.row = ci_s1;
		copy_key.col = cj_s1;
		if (k_s1 < nld_q) begin
			copy_key.slash = cm_rdata_q[grdk_pkg::COST_W];
			copy_key.cost  = cm_rdata_q[grdk_pkg::COST_W-1:0];
		end else begin
			copy_key.slash = 1'b0;
			copy_key.cost  = '0;
		end
	end

	// side ids of the cell held in jkey_q: top, right, bottom, left
	logic [NODE_W-1:0] s_top, s_right, s_bot, s_left;
	logic [NODE_W-1:0] ri, rj;

	assign ri      = NODE_W'(jkey_q.row);
	assign rj      = NODE_W'(jkey_q.col);
	assign s_top   = ri * NODE_W'(ec_q) + rj;
	assign s_bot   = (ri + NODE_W'(1)) * NODE_W'(ec_q) + rj;
	assign s_left  = rj * NODE_W'(er_q) + ri + pre_q;
	assign s_right = (rj + NODE_W'(1)) * NODE_W'(er_q) + ri + pre_q;

	// memory port control
	always_comb begin
		cm_we     = cell_wr;
		cm_raddr  = k_q[CELL_W-1:0];
		ord_raddr = k_q[CELL_W-1:0];
		orda_we   = 1'b0;
		ordb_we   = 1'b0;
		ord_waddr = hist_q[hx][CELL_W-1:0];
		ord_wdata = src_key;
		par_we    = 1'b0;
		par_waddr = cur_q;
		par_wdata = root_q;
		par_raddr = cur_q;
		unique case (state_q)
			S_COPY: begin
				orda_we   = v_s1;
				ord_waddr = k_s1[CELL_W-1:0];
				ord_wdata = copy_key;
			end
			S_SCT: begin
				orda_we = v_s1 && pass_q[0];
				ordb_we = v_s1 && !pass_q[0];
			end
			S_PINIT: begin
				par_we    = 1'b1;
				par_waddr = nd_q[NODE_W-1:0];
				par_wdata = nd_q[NODE_W-1:0];
			end
			S_CCHK: begin
				par_we = (par_rdata_q != root_q);
			end
			S_UNI: begin
				par_we    = (ra_q != root_q);
				par_waddr = ra_q;
				par_wdata = root_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cm_we)
			cell_mem[loaded_q[CELL_W-1:0]] <= {is_slash, cell_cost};
		cm_rdata_q <= cell_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (orda_we)
			ord_a[ord_waddr] <= ord_wdata;
		orda_rdata_q <= ord_a[ord_raddr];
	end

	always_ff @(posedge clk) begin
		if (ordb_we)
			ord_b[ord_waddr] <= ord_wdata;
		ordb_rdata_q <= ord_b[ord_raddr];
	end

	always_ff @(posedge clk) begin
		if (par_we)
			par_mem[par_waddr] <= par_wdata;
		par_rdata_q <= par_mem[par_raddr];
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= grdk_pkg::CFG_W'(1);
			cols_q      <= grdk_pkg::CFG_W'(1);
			loaded_q    <= '0;
			n_q         <= '0;
			nld_q       <= '0;
			k_q         <= '0;
			er_q        <= '0;
			ec_q        <= '0;
			pre_q       <= '0;
			nodes_q     <= '0;
			nd_q        <= '0;
			ci_q        <= '0;
			cj_q        <= '0;
			ci_s1       <= '0;
			cj_s1       <= '0;
			k_s1        <= '0;
			v_s1        <= 1'b0;
			pass_q      <= '0;
			for (int b = 0; b < grdk_pkg::NBUCKET; b++)
				hist_q[b] <= '0;
			b_q         <= '0;
			acc_q       <= '0;
			zpass_q     <= 1'b0;
			jkey_q      <= '0;
			ca_q        <= '0;
			cb_q        <= '0;
			e1a_q       <= '0;
			e1b_q       <= '0;
			e_q         <= 1'b0;
			side_q      <= 1'b0;
			cur_q       <= '0;
			root_q      <= '0;
			ra_q        <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_total_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					grdk_pkg::REG_ROWS: rows_q <= cfg_data;
					grdk_pkg::REG_COLS: cols_q <= cfg_data;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					loaded_q <= (in_acc && last_cell) ? '0 : loaded_nx;
					if (in_acc && last_cell) begin
						n_q      <= n_now;
						nld_q    <= nld_nx;
						er_q     <= er;
						ec_q     <= ec;
						pre_q    <= NODE_W'((NCNT_W'(er) + NCNT_W'(1)) * NCNT_W'(ec));
						nodes_q  <= (NCNT_W'(er) + NCNT_W'(1)) * NCNT_W'(ec)
							+ NCNT_W'(er) * (NCNT_W'(ec) + NCNT_W'(1));
						k_q      <= '0;
						ci_q     <= '0;
						cj_q     <= '0;
						v_s1     <= 1'b0;
						total_q  <= '0;
						state_q  <= S_COPY;
					end
				end
				S_COPY: begin
					v_s1  <= (k_q != n_q);
					k_s1  <= k_q;
					ci_s1 <= ci_q;
					cj_s1 <= cj_q;
					if (k_q != n_q) begin
						k_q <= k_q + CNT_W'(1);
						if (CDIM_W'(cj_q) + CDIM_W'(1) == ec_q) begin
							cj_q <= '0;
							ci_q <= ci_q + ROW_W'(1);
						end else begin
							cj_q <= cj_q + COL_W'(1);
						end
					end else if (!v_s1) begin
						nd_q    <= '0;
						state_q <= S_PINIT;
					end
				end
				S_PINIT: begin
					nd_q <= nd_q + NCNT_W'(1);
					if (nd_q + NCNT_W'(1) == nodes_q) begin
						pass_q <= '0;
						k_q    <= '0;
						for (int b = 0; b < grdk_pkg::NBUCKET; b++)
							hist_q[b] <= '0;
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					v_s1 <= (k_q != n_q);
					if (v_s1)
						hist_q[hx] <= hist_q[hx] + CNT_W'(1);
					if (k_q != n_q) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!v_s1) begin
						b_q     <= '0;
						acc_q   <= '0;
						state_q <= S_PFX;
					end
				end
				S_PFX: begin
					// histogram becomes the start offset of each bucket
					hist_q[hx] <= acc_q;
					acc_q      <= acc_q + hist_q[hx];
					b_q        <= b_q + DIGIT_W'(1);
					if (b_q == DIGIT_W'(grdk_pkg::NBUCKET - 1)) begin
						k_q     <= '0;
						state_q <= S_SCT;
					end
				end
				S_SCT: begin
					v_s1 <= (k_q != n_q);
					if (v_s1)
						hist_q[hx] <= hist_q[hx] + CNT_W'(1);
					if (k_q != n_q) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!v_s1) begin
						k_q <= '0;
						if (pass_q == PASS_W'(grdk_pkg::NDIGIT - 1)) begin
							zpass_q <= 1'b1;
							state_q <= S_JRD;
						end else begin
							pass_q <= pass_q + PASS_W'(1);
							for (int b = 0; b < grdk_pkg::NBUCKET; b++)
								hist_q[b] <= '0;
							state_q <= S_CNT;
						end
					end
				end
				S_JRD: begin
					if (k_q == n_q) begin
						if (zpass_q) begin
							zpass_q <= 1'b0;
							k_q     <= '0;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_JLAT;
					end
				end
				S_JLAT: begin
					jkey_q  <= sorted_key;
					state_q <= S_JSIDE;
				end
				S_JSIDE: begin
					// zero pass takes the free joins, cost pass the costed ones
					if (zpass_q == jkey_q.slash) begin
						ca_q  <= s_top;
						cb_q  <= s_left;
						e1a_q <= s_right;
						e1b_q <= s_bot;
						cur_q <= s_top;
					end else begin
						ca_q  <= s_top;
						cb_q  <= s_right;
						e1a_q <= s_bot;
						e1b_q <= s_left;
						cur_q <= s_top;
					end
					e_q     <= 1'b0;
					side_q  <= 1'b0;
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (par_rdata_q == cur_q) begin
						root_q  <= cur_q;
						cur_q   <= side_q ? cb_q : ca_q;
						state_q <= S_CRD;
					end else begin
						cur_q   <= par_rdata_q;
						state_q <= S_FRD;
					end
				end
				S_CRD: begin
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					// path compression walk, rewrites each parent on the way
					if (par_rdata_q != root_q) begin
						cur_q   <= par_rdata_q;
						state_q <= S_CRD;
					end else if (!side_q) begin
						ra_q    <= root_q;
						side_q  <= 1'b1;
						cur_q   <= cb_q;
						state_q <= S_FRD;
					end else begin
						state_q <= S_UNI;
					end
				end
				S_UNI: begin
					if (ra_q != root_q && !zpass_q)
						total_q <= total_q + TOTAL_W'(jkey_q.cost);
					side_q <= 1'b0;
					if (!e_q) begin
						e_q     <= 1'b1;
						ca_q    <= e1a_q;
						cb_q    <= e1b_q;
						cur_q   <= e1a_q;
						state_q <= S_FRD;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_JRD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_total_q <= total_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CNT_W'(grdk_pkg::MAX_CELLS))
		else $error("cell count beyond store depth");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished solve did not reach the output register");

	a_par_addr: assert property (@(posedge clk) disable iff (!arst_n)
		par_we |-> (NCNT_W'(par_waddr) < nodes_q))
		else $error("parent write outside the graph");

	a_ord_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(orda_we || ordb_we) |-> (CNT_W'(ord_waddr) < n_q))
		else $error("order write outside the grid");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_cell) |=> in_stall)
		else $error("final cell transfer did not start the solve");

endmodule

`default_nettype wire

// ===== dv/grid_forest_checker.sv =====
// grid diagonal-cut spanning forest checker: watches cfg, in and out channels
// predicts the forest weight per grid and compares it with total_cost; uses grdk_pkg
`timescale 1ns / 1ps

module grid_forest_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	input  wire                           cfg_ready,
	input  wire                           cfg_index,
	input  wire  [grdk_pkg::CFG_W-1:0]    cfg_data,
	input  wire                           in_valid,
	input  wire                           in_stall,
	input  wire                           is_slash,
	input  wire  [grdk_pkg::COST_W-1:0]   cell_cost,
	input  wire                           last_cell,
	input  wire                           out_valid,
	input  wire                           out_stall,
	input  wire  [grdk_pkg::TOTAL_W-1:0]  total_cost,
	output int                            errors,
	output int                            pending
);

	logic [grdk_pkg::CFG_W-1:0]   rows_q, cols_q;
	logic [grdk_pkg::CELL_DW-1:0] cells [grdk_pkg::MAX_CELLS];
	int unsigned                  parent [grdk_pkg::MAX_NODES];
	int unsigned                  loaded;
	logic [grdk_pkg::TOTAL_W-1:0] weight_q [$];

	assign pending = weight_q.size();

	function automatic int unsigned dim_eff(logic [grdk_pkg::CFG_W-1:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic int unsigned root_of(int unsigned x);
		int unsigned root, nxt;
		root = x;
		while (parent[root] != root)
			root = parent[root];
		while (parent[x] != root) begin
			nxt = parent[x];
			parent[x] = root;
			x = nxt;
		end
		return root;
	endfunction

	function automatic bit unite(int unsigned a, int unsigned b);
		int unsigned ra, rb;
		ra = root_of(a);
		rb = root_of(b);
		if (ra == rb)
			return 0;
		parent[ra] = rb;
		return 1;
	endfunction

	// top, right, bottom, left segment ids of a cell
	function automatic void sides(int unsigned idx, int unsigned r, int unsigned c,
			output int unsigned s0, output int unsigned s1,
			output int unsigned s2, output int unsigned s3);
		int unsigned i, j, pre;
		i = idx / c;
		j = idx % c;
		pre = (r + 1) * c;
		s0 = i * c + j;
		s1 = (j + 1) * r + i + pre;
		s2 = (i + 1) * c + j;
		s3 = j * r + i + pre;
	endfunction

	function automatic logic [grdk_pkg::TOTAL_W-1:0] forest_weight();
		int unsigned r, c, n, nodes, idx, cost, s0, s1, s2, s3;
		logic [grdk_pkg::TOTAL_W-1:0] sum;
		logic [27:0] order [$];
		r = dim_eff(rows_q, grdk_pkg::MAX_ROWS);
		c = dim_eff(cols_q, grdk_pkg::MAX_COLS);
		n = r * c;
		nodes = (r + 1) * c + r * (c + 1);
		sum = 0;
		// cells never sent count as zero-cost backslash
		for (int k = loaded; k < n; k++)
			cells[k] = '0;
		for (int k = 0; k < nodes; k++)
			parent[k] = k;
		for (int k = 0; k < n; k++) begin
			sides(k, r, c, s0, s1, s2, s3);
			if (cells[k][grdk_pkg::COST_W]) begin
				void'(unite(s0, s3));
				void'(unite(s1, s2));
			end else begin
				void'(unite(s0, s1));
				void'(unite(s2, s3));
			end
			order.insert(order.size(), {cells[k][grdk_pkg::COST_W-1:0], 12'(k)});
		end
		order.sort();
		foreach (order[k]) begin
			idx = order[k][11:0];
			cost = order[k][27:12];
			sides(idx, r, c, s0, s1, s2, s3);
			if (cells[idx][grdk_pkg::COST_W]) begin
				if (unite(s2, s3)) sum += cost;
				if (unite(s0, s1)) sum += cost;
			end else begin
				if (unite(s0, s3)) sum += cost;
				if (unite(s1, s2)) sum += cost;
			end
		end
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		if (!arst_n) begin
			rows_q = grdk_pkg::CFG_W'(1);
			cols_q = grdk_pkg::CFG_W'(1);
			loaded = 0;
			errors = 0;
			weight_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == grdk_pkg::REG_ROWS)
					rows_q = cfg_data;
				else
					cols_q = cfg_data;
			end
			if (in_valid && !in_stall) begin
				n = dim_eff(rows_q, grdk_pkg::MAX_ROWS) * dim_eff(cols_q, grdk_pkg::MAX_COLS);
				if (loaded < n) begin
					cells[loaded] = {is_slash, cell_cost};
					loaded++;
				end
				if (last_cell) begin
					weight_q.insert(weight_q.size(), forest_weight());
					loaded = 0;
				end
			end
			if (out_valid && !out_stall) begin
				if (weight_q.size() == 0) begin
					$error("unexpected total_cost transfer: actual %0d", total_cost);
					errors++;
				end else begin
					if (total_cost !== weight_q[0]) begin
						$error("total_cost mismatch: expected %0d actual %0d",
							weight_q[0], total_cost);
						errors++;
					end
					void'(weight_q.pop_front());
				end
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
// testbench top for grid_diagonal_cut_kruskal_mst_top: clock, reset, stimulus, verdict
// depends on grdk_pkg, the block and grid_forest_checker
`timescale 1ns / 1ps

module testbench;

	localparam int IDLE_LIMIT = 5000000;

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          cfg_valid = 0;
	logic                          cfg_index = 0;
	logic [grdk_pkg::CFG_W-1:0]    cfg_data = 0;
	logic                          in_valid = 0;
	logic                          is_slash = 0;
	logic [grdk_pkg::COST_W-1:0]   cell_cost = 0;
	logic                          last_cell = 0;
	logic                          out_stall = 0;
	wire                           cfg_ready, in_stall, out_valid;
	wire [grdk_pkg::TOTAL_W-1:0]   total_cost;
	int                            errors, pending;
	int                            burst_left = 0;
	int                            sent = 0;
	int                            idle_cycles = 0;
	int                            stall_mode = 0;
	int                            stall_cnt = 0;

	always #10 clk = ~clk;

	grid_diagonal_cut_kruskal_mst_top dut (.*);

	grid_forest_checker checker_i (.*);

	// receiver stall pattern switches between four randomly drawn modes
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= (stall_cnt % 64) < 40;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("grid_diagonal_cut_kruskal_mst_top regression: fail");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [grdk_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// pause until every forest weight has come out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_grid(logic [grdk_pkg::CFG_W-1:0] r, logic [grdk_pkg::CFG_W-1:0] c);
		drain();
		write_reg(grdk_pkg::REG_ROWS, r);
		write_reg(grdk_pkg::REG_COLS, c);
	endtask

	task automatic send_cell(logic s, logic [grdk_pkg::COST_W-1:0] cost, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		is_slash <= s;
		cell_cost <= cost;
		last_cell <= last;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sent++;
	endtask

	function automatic logic [grdk_pkg::CFG_W-1:0] rand_dim();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return grdk_pkg::CFG_W'($urandom_range(65, 127));
			2: return grdk_pkg::CFG_W'($urandom_range(9, 64));
			default: return grdk_pkg::CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int unsigned r, c, n, cnt, lim;
		logic [grdk_pkg::COST_W-1:0] cmax;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single cell, both diagonals, cost extremes
		send_cell(1'b1, 16'd0, 1'b1);
		send_cell(1'b0, 16'hFFFF, 1'b1);
		set_grid(7'd2, 7'd2);
		send_cell(1'b1, 16'hFFFF, 1'b0);
		send_cell(1'b0, 16'd0, 1'b0);
		send_cell(1'b0, 16'hFFFF, 1'b0);
		send_cell(1'b1, 16'd1, 1'b1);
		// extra cells beyond the grid are dropped
		set_grid(7'd1, 7'd2);
		send_cell(1'b0, 16'd5, 1'b0);
		send_cell(1'b1, 16'd7, 1'b0);
		send_cell(1'b1, 16'd9, 1'b0);
		send_cell(1'b0, 16'd3, 1'b1);
		// grid ended early
		set_grid(7'd3, 7'd3);
		send_cell(1'b1, 16'd100, 1'b0);
		send_cell(1'b0, 16'd200, 1'b1);
		// out-of-range register values, then the largest grid ended early
		set_grid(7'd0, 7'd127);
		send_cell(1'b1, 16'h8000, 1'b0);
		send_cell(1'b0, 16'h7FFF, 1'b1);
		set_grid(7'd127, 7'd0);
		send_cell(1'b1, 16'd42, 1'b1);
		set_grid(7'd64, 7'd64);
		send_cell(1'b1, 16'hFFFF, 1'b0);
		send_cell(1'b0, 16'h0001, 1'b0);
		send_cell(1'b1, 16'hAAAA, 1'b1);

		while (sent < 2000) begin
			r = rand_dim();
			c = rand_dim();
			// keep big grids rare and narrow in the other dimension
			if (r > 8 && c > 8)
				c = $urandom_range(0, 4);
			set_grid(grdk_pkg::CFG_W'(r), grdk_pkg::CFG_W'(c));
			n = ((r == 0) ? 1 : (r > 64 ? 64 : r)) * ((c == 0) ? 1 : (c > 64 ? 64 : c));
			case ($urandom_range(0, 19))
				0, 1, 2: cnt = $urandom_range(1, n);
				3, 4: cnt = n + $urandom_range(1, 3);
				default: cnt = n;
			endcase
			lim = $urandom_range(0, 2);
			cmax = (lim == 0) ? 16'd3 : (lim == 1) ? 16'd255 : 16'hFFFF;
			for (int k = 0; k < cnt; k++)
				send_cell(1'($urandom_range(0, 1)),
					grdk_pkg::COST_W'($urandom_range(0, cmax)), k == cnt - 1);
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("grid_diagonal_cut_kruskal_mst_top regression: pass");
		else
			$display("grid_diagonal_cut_kruskal_mst_top regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/grdk_pkg.sv
rtl/grid_diagonal_cut_kruskal_mst_top.sv
dv/grid_forest_checker.sv
dv/testbench.sv
